// File: src/udp_frame_header_parser_macros.svh
// ---------------------------------------------------------------------------
// udp_frame_header_parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef UDP_FRAME_HEADER_PARSER_MACROS_SVH
`define UDP_FRAME_HEADER_PARSER_MACROS_SVH

// condition holds at every edge outside reset
`define UDPFHP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define UDPFHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/udpfhp_pkg.sv
// ---------------------------------------------------------------------------
// udpfhp_pkg
// Word types, status codes and header offsets for the UDP frame header parser.
// ---------------------------------------------------------------------------
package udpfhp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_UDP      = 3'd0,
    ST_OWN      = 3'd1,
    ST_NOT_IPV4 = 3'd2,
    ST_BAD_HDR  = 3'd3,
    ST_NOT_UDP  = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  // byte offsets within the frame
  localparam int unsigned POS_W      = 6;
  localparam logic [POS_W-1:0] MAC_START  = 6'd6;
  localparam logic [POS_W-1:0] MAC_END    = 6'd12;
  localparam logic [POS_W-1:0] ET_END     = 6'd14;
  localparam logic [POS_W-1:0] IP_START   = 6'd14;
  localparam logic [POS_W-1:0] IP_END     = 6'd34;
  localparam logic [POS_W-1:0] HEADER_END = 6'd42;

  // field values checked
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
  localparam logic [15:0] SUM_OK         = 16'hFFFF;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        checksum_ok;
    logic [15:0] ether_type;
    logic [15:0] ip_total_length;
    logic [15:0] ip_ident;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_length;
    logic [7:0]  udp_frame_count;
  } out_item_t;

  // input register contents handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // parser handshake toward the input and output registers
  typedef struct packed {
    logic consume;
    logic res_valid;
  } parse_ctl_t;

endpackage

// File: src/udpfhp_in_stage.sv
// ---------------------------------------------------------------------------
// udpfhp_in_stage
// Input register: holds one frame byte until the parser takes it.
// ---------------------------------------------------------------------------
module udpfhp_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  udpfhp_pkg::in_item_t in_data,
  input  logic                 consume,
  output udpfhp_pkg::stage_t   stage
);
  import udpfhp_pkg::*;

  logic     stage_valid;
  in_item_t stage_item;

  // free when empty or being drained this cycle
  assign in_ready = !stage_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  assign stage.valid = stage_valid;
  assign stage.item  = stage_item;

endmodule

// File: src/udpfhp_parser.sv
// ---------------------------------------------------------------------------
// udpfhp_parser
// Frame state (position, MAC shift, header sum, captured fields) and the
// per-frame verdict formed on the last byte.
// ---------------------------------------------------------------------------
`include "udp_frame_header_parser_macros.svh"

module udpfhp_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [47:0]            cfg_data,
  input  udpfhp_pkg::stage_t     stage,
  input  logic                   out_free,
  output udpfhp_pkg::parse_ctl_t ctl,
  output udpfhp_pkg::out_item_t  res
);
  import udpfhp_pkg::*;

  logic [47:0]      own_mac;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [47:0]      source_mac, source_mac_next;
  logic [15:0]      header_sum, header_sum_next;
  logic [7:0]       high_byte_hold, high_byte_hold_next;
  logic [7:0]       first_header_byte, first_header_byte_next;
  logic [7:0]       protocol_byte, protocol_byte_next;
  logic [7:0]       frame_counter, frame_counter_next;
  out_item_t        fields, fields_next;

  logic [7:0]       b;
  logic             take;
  logic             advance;
  logic             frame_end;
  logic [16:0]      sum_wide;
  status_t          status;
  logic             ck;
  logic             full;

  assign b         = stage.item.frame_byte;
  // last byte waits until the result register can load
  assign advance   = stage.valid && (!stage.item.last_byte || out_free);
  assign frame_end = advance && stage.item.last_byte;
  assign take      = byte_position < HEADER_END;
  assign sum_wide  = {1'b0, header_sum} + {1'b0, high_byte_hold, b};

  assign ctl.consume   = advance;
  assign ctl.res_valid = frame_end;

  // own address register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
    end else if (cfg_we) begin
      own_mac <= cfg_data;
    end
  end

  // byte capture for the current position
  always_comb begin
    byte_position_next     = byte_position;
    source_mac_next        = source_mac;
    header_sum_next        = header_sum;
    high_byte_hold_next    = high_byte_hold;
    first_header_byte_next = first_header_byte;
    protocol_byte_next     = protocol_byte;
    fields_next            = fields;
    if (take) begin
      byte_position_next = byte_position + 1'b1;
      if (byte_position >= MAC_START && byte_position < MAC_END) begin
        source_mac_next = {source_mac[39:0], b};
      end
      // ones-complement sum over the IPv4 header words, end-around carry
      if (byte_position >= IP_START && byte_position < IP_END) begin
        if (!byte_position[0]) begin
          high_byte_hold_next = b;
        end else begin
          header_sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
        end
      end
      case (byte_position)
        6'd12: fields_next.ether_type[15:8]      = b;
        6'd13: fields_next.ether_type[7:0]       = b;
        6'd14: first_header_byte_next            = b;
        6'd16: fields_next.ip_total_length[15:8] = b;
        6'd17: fields_next.ip_total_length[7:0]  = b;
        6'd18: fields_next.ip_ident[15:8]        = b;
        6'd19: fields_next.ip_ident[7:0]         = b;
        6'd23: protocol_byte_next                = b;
        6'd26: fields_next.src_ip[31:24]         = b;
        6'd27: fields_next.src_ip[23:16]         = b;
        6'd28: fields_next.src_ip[15:8]          = b;
        6'd29: fields_next.src_ip[7:0]           = b;
        6'd30: fields_next.dst_ip[31:24]         = b;
        6'd31: fields_next.dst_ip[23:16]         = b;
        6'd32: fields_next.dst_ip[15:8]          = b;
        6'd33: fields_next.dst_ip[7:0]           = b;
        6'd34: fields_next.src_port[15:8]        = b;
        6'd35: fields_next.src_port[7:0]         = b;
        6'd36: fields_next.dst_port[15:8]        = b;
        6'd37: fields_next.dst_port[7:0]         = b;
        6'd38: fields_next.udp_length[15:8]      = b;
        6'd39: fields_next.udp_length[7:0]       = b;
        default: ;
      endcase
    end
  end

  // verdict, judged on the state including the last byte
  always_comb begin
    ck   = 1'b0;
    full = 1'b0;
    if (byte_position_next < MAC_END) begin
      status = ST_TRUNC;
    end else if (source_mac_next == own_mac) begin
      status = ST_OWN;
    end else if (byte_position_next < ET_END) begin
      status = ST_TRUNC;
    end else if (fields_next.ether_type != ETHERTYPE_IPV4) begin
      status = ST_NOT_IPV4;
    end else if (byte_position_next < IP_END) begin
      status = ST_TRUNC;
    end else begin
      ck = header_sum_next == SUM_OK;
      if (first_header_byte_next != IP_VER_IHL) begin
        status = ST_BAD_HDR;
      end else if (protocol_byte_next != IP_PROTO_UDP) begin
        status = ST_NOT_UDP;
      end else if (byte_position_next < HEADER_END) begin
        status = ST_TRUNC;
        ck     = 1'b0;
      end else begin
        status = ST_UDP;
        full   = 1'b1;
      end
    end
  end

  assign frame_counter_next = frame_counter + {7'd0, full};

  // result word
  always_comb begin
    res             = '0;
    res.status      = status;
    res.checksum_ok = ck;
    res.ether_type  = (byte_position_next >= ET_END) ? fields_next.ether_type : 16'd0;
    if (full) begin
      res.ip_total_length = fields_next.ip_total_length;
      res.ip_ident        = fields_next.ip_ident;
      res.src_ip          = fields_next.src_ip;
      res.dst_ip          = fields_next.dst_ip;
      res.src_port        = fields_next.src_port;
      res.dst_port        = fields_next.dst_port;
      res.udp_length      = fields_next.udp_length;
    end
    res.udp_frame_count = frame_counter_next;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      source_mac        <= '0;
      header_sum        <= '0;
      high_byte_hold    <= '0;
      first_header_byte <= '0;
      protocol_byte     <= '0;
      frame_counter     <= '0;
      fields            <= '0;
    end else if (advance) begin
      source_mac        <= source_mac_next;
      high_byte_hold    <= high_byte_hold_next;
      first_header_byte <= first_header_byte_next;
      protocol_byte     <= protocol_byte_next;
      fields            <= fields_next;
      if (stage.item.last_byte) begin
        byte_position <= '0;
        header_sum    <= '0;
        frame_counter <= frame_counter_next;
      end else begin
        byte_position <= byte_position_next;
        header_sum    <= header_sum_next;
      end
    end
  end

  `UDPFHP_ASSERT(a_pos_saturates, byte_position <= HEADER_END, "byte position past header end")
  `UDPFHP_ASSERT_NEXT(a_frame_restart, frame_end, byte_position == '0 && header_sum == '0,
                      "frame state not cleared after last byte")
  `UDPFHP_ASSERT_NEXT(a_count_on_parse, !(frame_end && full), $stable(frame_counter),
                      "frame count moved without a parsed UDP frame")

endmodule

// File: src/udpfhp_out_stage.sv
// ---------------------------------------------------------------------------
// udpfhp_out_stage
// Result register: holds one verdict word until the consumer takes it.
// ---------------------------------------------------------------------------
module udpfhp_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  udpfhp_pkg::out_item_t res,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output udpfhp_pkg::out_item_t out_data
);
  import udpfhp_pkg::*;

  logic      res_valid;
  out_item_t res_word;

  // loadable when empty or draining this cycle
  assign out_free = !res_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_word <= res;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_word;

endmodule

// File: src/udp_frame_header_parser.sv
// ---------------------------------------------------------------------------
// udp_frame_header_parser
// Ethernet / IPv4 / UDP header parser, one frame byte per word.
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle with no gaps needed, except while a last byte
// waits for the result register; one result word per frame. The last byte
// lands in the input register, and the verdict formed from it loads the
// result register once that register is free, so the output handshake
// follows the last byte's. The parse logic between the two registers
// holds a byte counter, a 16-bit end-around-carry adder for the IPv4 header
// sum and byte-capture registers; bytes past offset 41 are counted out and
// ignored. A finished result may wait in the result register while the next
// frame's bytes keep flowing; only a following last byte waits for that
// register to drain. The own MAC is written through cfg_valid/cfg_data,
// always ready, and should be changed only while no frame is in progress.
// ---------------------------------------------------------------------------
`include "udp_frame_header_parser_macros.svh"

module udp_frame_header_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  udpfhp_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output udpfhp_pkg::out_item_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [47:0]           cfg_data
);
  import udpfhp_pkg::*;

  stage_t     stage;
  parse_ctl_t ctl;
  out_item_t  res;
  logic       out_free;

  assign cfg_ready = 1'b1;

  udpfhp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .consume  (ctl.consume),
    .stage    (stage)
  );

  udpfhp_parser u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stage    (stage),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  udpfhp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ctl.res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `UDPFHP_ASSERT(a_result_has_room, !ctl.res_valid || out_free,
                 "result produced while result register is full")
  `UDPFHP_ASSERT(a_result_on_last, !ctl.res_valid || (stage.valid && stage.item.last_byte),
                 "result produced without a last byte")
  `UDPFHP_ASSERT_NEXT(a_result_lands, ctl.res_valid, out_valid,
                      "result word did not reach the output")

endmodule
